>>> rtl/core/texel_to_argb8888_converter_defines.svh
// Assertion macros for the texel to ARGB8888 converter.
// Used by the top level only; expects clk and rst in scope.
`ifndef TEXEL_TO_ARGB8888_CONVERTER_DEFINES_SVH
`define TEXEL_TO_ARGB8888_CONVERTER_DEFINES_SVH

// same-cycle implication
`define T2A_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("t2a assertion failed");

// next-cycle implication
`define T2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("t2a assertion failed");

`endif

>>> rtl/core/t2a_pkg.sv
// Shared types, codes and decode functions for the texel converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package t2a_pkg;

  localparam int PaletteDepthDefault = 256;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [1:0] ACT_CONVERT   = 2'd0;
  localparam logic [1:0] ACT_PAL_WRITE = 2'd1;
  localparam logic [1:0] ACT_PAL_RESET = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_TEXEL_FORMAT   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_FORMAT = 1'd1;

  localparam logic [7:0] TEXEL_FORMAT_RESET   = 8'h78;
  localparam logic [7:0] PALETTE_FORMAT_RESET = 8'h2A;

  localparam logic [6:0] FMT_ARGB4444 = 7'h6D;
  localparam logic [6:0] FMT_ARGB1555 = 7'h7E;
  localparam logic [6:0] FMT_BGRA32   = 7'h7D;
  localparam logic [6:0] FMT_BGR24    = 7'h7F;
  localparam logic [6:0] FMT_INDEX8   = 7'h7B;
  localparam logic [6:0] FMT_RGB565   = 7'h78;

  localparam logic [7:0] PAL_ARGB32_A = 8'h2A;
  localparam logic [7:0] PAL_ARGB32_B = 8'h24;
  localparam logic [7:0] PAL_RGB24    = 8'h22;
  localparam logic [7:0] PAL_ARGB1555 = 8'h2D;

  localparam logic [15:0] TEXEL_TRANSPARENT = 16'h0001;

  // floor(x*255/31)
  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic        clr;
    logic [7:0]  slot;
    logic [31:0] wr_data;
  } pal_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] data;
  } pal_rsp_t;

  // floor(x*255/63) = 4x + floor(x/21)
  function automatic logic [7:0] scale6(input logic [5:0] x);
    logic [1:0] frac;
    frac = 2'((x >= 6'd21) ? 1 : 0) + 2'((x >= 6'd42) ? 1 : 0) + 2'((x == 6'd63) ? 1 : 0);
    return {x, 2'b00} + {6'd0, frac};
  endfunction

  function automatic logic [31:0] decode16(input logic [15:0] v, input logic [6:0] sel);
    logic [31:0] res;
    if (v == TEXEL_TRANSPARENT) begin
      res = 32'd0;
    end else if (sel == FMT_ARGB4444) begin
      res = {v[15:12], v[15:12], v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
    end else if (sel == FMT_ARGB1555) begin
      res = {{8{v[15]}}, SCALE5[v[14:10]], SCALE5[v[9:5]], SCALE5[v[4:0]]};
    end else begin
      res = {8'hFF, SCALE5[v[15:11]], scale6(v[10:5]), SCALE5[v[4:0]]};
    end
    return res;
  endfunction

  function automatic logic [31:0] grey_of(input logic [7:0] idx);
    return {8'hFF, idx, idx, idx};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/t2a_channels_if.sv
// Valid/ready channel interfaces for texel input and pixel output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface t2a_texel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] raw_value;
  logic [7:0]  palette_slot;

  modport source (output valid, action, raw_value, palette_slot, input ready);
  modport sink   (input valid, action, raw_value, palette_slot, output ready);
endinterface

interface t2a_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_pixel;

  modport source (output valid, argb_pixel, input ready);
  modport sink   (input valid, argb_pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/core/texel_to_argb8888_converter.sv
// Texel to ARGB8888 converter top level: config registers, pipeline, output register.
// Depends on t2a_pkg, t2a_channels_if, t2a_texel_decode, t2a_palette.
//
//  channel | dir | payload                              | transaction when
//  texel   | in  | action, raw_value, palette_slot      | texel.valid & texel.ready
//  pixel   | out | argb_pixel                           | pixel.valid & pixel.ready
//  cfg     | in  | cfg_index, cfg_data                  | cfg_write
//
// One transaction per cycle sustained while pixel.ready stays high; a convert result passes
// through the palette RAM read, then the output register.
// Palette writes and resets take effect at acceptance and are seen by the next item.
// Synchronous reset clears all loaded bits at once; the block is ready right after.
// A stalled output holds one result while one more item waits in the lookup stage.
`timescale 1ns / 1ps
`default_nettype none
`include "texel_to_argb8888_converter_defines.svh"

module texel_to_argb8888_converter
  import t2a_pkg::*;
#(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  t2a_texel_if.sink                texel,
  t2a_pixel_if.source              pixel
);

  logic [7:0]  texel_format;
  logic [7:0]  palette_format;
  logic [31:0] direct_pixel;
  logic [31:0] palette_entry;
  logic        use_palette;
  logic        accept;
  logic        is_convert;
  pal_req_t    req;
  pal_rsp_t    rsp;

  logic        s1_valid;
  logic        s1_use_pal;
  logic [7:0]  s1_idx;
  logic [31:0] s1_direct;
  logic [31:0] s1_pixel;
  logic        s1_move;

  logic        out_valid;
  logic [31:0] out_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format   <= TEXEL_FORMAT_RESET;
      palette_format <= PALETTE_FORMAT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEXEL_FORMAT:   texel_format   <= cfg_data;
        CFG_PALETTE_FORMAT: palette_format <= cfg_data;
        default: ;
      endcase
    end
  end

  t2a_texel_decode u_decode (
    .texel_format  (texel_format),
    .palette_format(palette_format),
    .raw_value     (texel.raw_value),
    .direct_pixel  (direct_pixel),
    .use_palette   (use_palette),
    .palette_entry (palette_entry)
  );

  assign s1_move     = s1_valid && (!out_valid || pixel.ready);
  assign texel.ready = !s1_valid || s1_move;
  assign accept      = texel.valid && texel.ready;
  assign is_convert  = texel.action == ACT_CONVERT;

  always_comb begin
    req.wr_en   = accept && texel.action == ACT_PAL_WRITE;
    req.rd_en   = accept && is_convert;
    req.clr     = accept && texel.action == ACT_PAL_RESET;
    req.slot    = is_convert ? texel.raw_value[7:0] : texel.palette_slot;
    req.wr_data = palette_entry;
  end

  t2a_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_convert;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_convert) begin
      s1_use_pal <= use_palette;
      s1_idx     <= texel.raw_value[7:0];
      s1_direct  <= direct_pixel;
    end
  end

  assign s1_pixel = !s1_use_pal ? s1_direct : (rsp.hit ? rsp.data : grey_of(s1_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pixel <= s1_pixel;
    end
  end

  assign pixel.valid      = out_valid;
  assign pixel.argb_pixel = out_pixel;

  `T2A_ASSERT_NEXT(a_convert_enters_s1, accept && is_convert, s1_valid)
  `T2A_ASSERT_NEXT(a_other_leaves_s1_empty, accept && !is_convert, !s1_valid)
  `T2A_ASSERT_NEXT(a_s1_holds_lookup, s1_valid && !s1_move,
                   s1_valid && $stable(s1_idx) && $stable(rsp.data) && $stable(rsp.hit))
  `T2A_ASSERT_NOW(a_no_read_while_held, s1_valid && !s1_move, !req.rd_en && !req.wr_en)

endmodule

`default_nettype wire

>>> rtl/core/t2a_texel_decode.sv
// Format decode: direct texel conversion and palette entry formatting.
// Depends on t2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module t2a_texel_decode
  import t2a_pkg::*;
(
  input  wire logic [7:0]  texel_format,
  input  wire logic [7:0]  palette_format,
  input  wire logic [31:0] raw_value,
  output logic      [31:0] direct_pixel,
  output logic             use_palette,
  output logic      [31:0] palette_entry
);

  logic [6:0] sel;
  assign sel = texel_format[6:0];

  always_comb begin
    use_palette = 1'b0;
    case (sel)
      FMT_BGRA32: direct_pixel = raw_value;
      FMT_BGR24:  direct_pixel = {8'hFF, raw_value[23:0]};
      FMT_INDEX8: begin
        direct_pixel = 32'd0;
        use_palette  = 1'b1;
      end
      default:    direct_pixel = decode16(raw_value[15:0], sel);
    endcase
  end

  always_comb begin
    case (palette_format)
      PAL_ARGB32_A, PAL_ARGB32_B: palette_entry = raw_value;
      PAL_RGB24:    palette_entry = {8'hFF, raw_value[7:0], raw_value[15:8], raw_value[23:16]};
      PAL_ARGB1555: palette_entry = decode16(raw_value[15:0], FMT_ARGB1555);
      default:      palette_entry = decode16(raw_value[15:0], FMT_RGB565);
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/t2a_palette.sv
// Palette RAM with per-entry loaded bits and a registered read port.
// Depends on t2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module t2a_palette
  import t2a_pkg::*;
#(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pal_req_t req,
  output pal_rsp_t      rsp
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [31:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] loaded;
  logic [AW-1:0]            addr;
  logic                     in_range;
  logic [31:0]              rd_data;
  logic                     rd_hit;

  assign addr     = req.slot[AW-1:0];
  assign in_range = {1'b0, req.slot} < 9'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      mem[addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (req.clr) begin
        loaded <= '0;
      end else if (req.wr_en && in_range) begin
        loaded[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= in_range && loaded[addr];
      end
    end
  end

  assign rsp = '{hit: rd_hit, data: rd_data};

endmodule

`default_nettype wire
